/* hdl/vlbs_pkg.sv */
package vlbs_pkg;

    // default geometry
    localparam int CAPACITY_DEF       = 1024;
    localparam int HEADER_BYTES_DEF   = 4;
    localparam int MAX_ELEM_BYTES_DEF = 8;

    // operation codes
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_CHECK = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // input item
    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] data_in;
        logic [3:0]  length;
    } vlbs_in_t;

    // result item
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] data_out;
        logic [3:0]  out_length;
        logic        is_empty;
        logic        would_be_full;
    } vlbs_out_t;

    // byte memory access request
    typedef struct packed {
        logic en;
        logic we;
    } vlbs_mem_req_t;

endpackage

/* hdl/variable_length_byte_stack_core.sv */
// Variable-length byte stack: elements of 0 to MAX_ELEM_BYTES bytes are kept
// in a CAPACITY-byte single-port memory growing down from the top address,
// each with a HEADER_BYTES little-endian length header at its low end. The
// memory moves one byte per cycle, and that port sets the rate: a push writes
// the header bytes and then its data bytes, a pop or peek reads the header,
// waits for the last read, clips the length and then reads the data bytes it
// copies, and clear, check and empty or full refusals use no memory access.
// Memory contents are not cleared at reset, so no clearing pass is needed. A
// finished result sits in an output register, so the next item is accepted
// while the previous result waits for m_ready.
module variable_length_byte_stack_core #(
    parameter int CAPACITY       = vlbs_pkg::CAPACITY_DEF,
    parameter int HEADER_BYTES   = vlbs_pkg::HEADER_BYTES_DEF,
    parameter int MAX_ELEM_BYTES = vlbs_pkg::MAX_ELEM_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vlbs_pkg::vlbs_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vlbs_pkg::vlbs_out_t m_data
);

    localparam int AW = $clog2(CAPACITY);

    vlbs_pkg::vlbs_mem_req_t mem_req;
    logic [AW-1:0]           mem_addr;
    logic [7:0]              mem_wdata;
    logic [7:0]              mem_rdata;
    logic                    res_valid;
    logic                    res_ready;
    vlbs_pkg::vlbs_out_t     res_item;
    logic                    m_valid_reg;
    vlbs_pkg::vlbs_out_t     m_data_reg;

    vlbs_ctrl #(
        .CAPACITY       (CAPACITY),
        .HEADER_BYTES   (HEADER_BYTES),
        .MAX_ELEM_BYTES (MAX_ELEM_BYTES),
        .AW             (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .mem_req   (mem_req),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    vlbs_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= res_item;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hdl/vlbs_mem.sv */
module vlbs_mem #(
    parameter int DEPTH = vlbs_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    aclk,
    input  vlbs_pkg::vlbs_mem_req_t req,
    input  logic [AW-1:0]           addr,
    input  logic [7:0]              wdata,
    output logic [7:0]              rdata
);

    logic [7:0] mem [DEPTH];

    // single port byte ram, registered read
    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* hdl/vlbs_ctrl.sv */
module vlbs_ctrl #(
    parameter int CAPACITY       = vlbs_pkg::CAPACITY_DEF,
    parameter int HEADER_BYTES   = vlbs_pkg::HEADER_BYTES_DEF,
    parameter int MAX_ELEM_BYTES = vlbs_pkg::MAX_ELEM_BYTES_DEF,
    parameter int AW             = $clog2(CAPACITY)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  vlbs_pkg::vlbs_in_t      in_item,
    output logic                    res_valid,
    input  logic                    res_ready,
    output vlbs_pkg::vlbs_out_t     res_item,
    output vlbs_pkg::vlbs_mem_req_t mem_req,
    output logic [AW-1:0]           mem_addr,
    output logic [7:0]              mem_wdata,
    input  logic [7:0]              mem_rdata
);

    localparam int TW  = $clog2(CAPACITY + 1);
    localparam int SW  = TW + 1;
    localparam int HIW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

    localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);
    localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
    localparam logic [TW-1:0] HB_T  = TW'(HEADER_BYTES);
    localparam logic [SW-1:0] HB_S  = SW'(HEADER_BYTES);
    localparam logic [3:0]    HB_4  = 4'(HEADER_BYTES);
    localparam logic [3:0]    MAXL  = 4'(MAX_ELEM_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_PUSH  = 4'd2;
    localparam logic [3:0] S_HDR   = 4'd3;
    localparam logic [3:0] S_HWAIT = 4'd4;
    localparam logic [3:0] S_SAT   = 4'd5;
    localparam logic [3:0] S_DATA  = 4'd6;
    localparam logic [3:0] S_DWAIT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]    state_reg;
    logic [TW-1:0] top_reg;
    logic [2:0]    op_reg;
    logic [63:0]   data_reg;
    logic [3:0]    len_reg;
    logic [3:0]    cnt_reg;
    logic [SW-1:0] base_reg;
    logic [3:0]    n_reg;
    logic [1:0]    status_reg;
    logic          wbf_reg;
    logic          rd_en_reg;
    logic          rd_hdr_reg;
    logic [3:0]    rd_slot_reg;
    logic          rd_oob_reg;
    logic [7:0]    hdr_b [HEADER_BYTES];
    logic [7:0]    dat_b [8];

    logic [3:0]    in_len_sat;
    logic [SW-1:0] need_s;
    logic          fits;
    logic [SW-1:0] push_top_s;
    logic [SW-1:0] addr_s;
    logic          hdr_oob;
    logic [31:0]   hdr_val;
    logic [3:0]    stored_c;
    logic [TW-1:0] room;
    logic [TW-1:0] room_h;
    logic [3:0]    stored2;
    logic [3:0]    n_c;
    logic [SW-1:0] pop_top_s;
    logic [TW-1:0] pop_top;
    logic [3:0]    wsel;
    logic [7:0]    cap_byte;

    // request length clipped to the element limit
    assign in_len_sat = (in_item.length > MAXL) ? MAXL : in_item.length;

    // room check for push and check
    assign need_s     = HB_S + SW'(len_reg);
    assign fits       = SW'(top_reg) >= need_s;
    assign push_top_s = SW'(top_reg) - need_s;

    // header value and stored length clipping
    always_comb begin
        hdr_val = '0;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            hdr_val[8*i +: 8] = hdr_b[i];
        end
    end

    assign stored_c  = (hdr_val > 32'(MAX_ELEM_BYTES)) ? MAXL : hdr_val[3:0];
    assign room      = CAP_T - top_reg;
    assign room_h    = (room > HB_T) ? (room - HB_T) : '0;
    assign stored2   = (TW'(stored_c) > room_h) ? room_h[3:0] : stored_c;
    assign n_c       = (len_reg < stored2) ? len_reg : stored2;
    assign pop_top_s = SW'(top_reg) + HB_S + SW'(stored2);
    assign pop_top   = (pop_top_s > CAP_S) ? CAP_T : pop_top_s[TW-1:0];

    // memory request per state
    assign wsel = cnt_reg - HB_4;

    always_comb begin
        mem_req   = '0;
        mem_wdata = '0;
        addr_s    = '0;
        hdr_oob   = 1'b0;
        case (state_reg)
            S_PUSH: begin
                mem_req.en = 1'b1;
                mem_req.we = 1'b1;
                addr_s     = base_reg + SW'(cnt_reg);
                if (cnt_reg < HB_4) begin
                    mem_wdata = (cnt_reg == 4'd0) ? {4'd0, len_reg} : 8'd0;
                end else begin
                    mem_wdata = data_reg[8*wsel[2:0] +: 8];
                end
            end
            S_HDR: begin
                addr_s     = SW'(top_reg) + SW'(cnt_reg);
                hdr_oob    = addr_s >= CAP_S;
                mem_req.en = !hdr_oob;
            end
            S_DATA: begin
                mem_req.en = 1'b1;
                addr_s     = base_reg + SW'(cnt_reg);
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    assign mem_addr = addr_s[AW-1:0];
    assign cap_byte = rd_oob_reg ? 8'd0 : mem_rdata;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            top_reg   <= CAP_T;
            rd_en_reg <= 1'b0;
        end else begin
            // a read issued in this cycle is captured in the next one
            rd_en_reg <= (state_reg == S_HDR) || (state_reg == S_DATA);

            // capture read data in the cycle after the request
            if (rd_en_reg) begin
                if (rd_hdr_reg) begin
                    hdr_b[rd_slot_reg[HIW-1:0]] <= cap_byte;
                end else begin
                    dat_b[rd_slot_reg[2:0]] <= cap_byte;
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        op_reg    <= in_item.op;
                        data_reg  <= in_item.data_in;
                        len_reg   <= in_len_sat;
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    status_reg <= vlbs_pkg::ST_OK;
                    wbf_reg    <= 1'b0;
                    n_reg      <= '0;
                    cnt_reg    <= '0;
                    for (int i = 0; i < 8; i++) begin
                        dat_b[i] <= '0;
                    end
                    case (op_reg)
                        vlbs_pkg::OP_PUSH: begin
                            if (fits) begin
                                base_reg  <= push_top_s;
                                state_reg <= S_PUSH;
                            end else begin
                                status_reg <= vlbs_pkg::ST_FULL;
                                state_reg  <= S_OUT;
                            end
                        end
                        vlbs_pkg::OP_POP, vlbs_pkg::OP_PEEK: begin
                            if (top_reg >= CAP_T) begin
                                status_reg <= vlbs_pkg::ST_EMPTY;
                                state_reg  <= S_OUT;
                            end else begin
                                state_reg <= S_HDR;
                            end
                        end
                        vlbs_pkg::OP_CLEAR: begin
                            top_reg   <= CAP_T;
                            state_reg <= S_OUT;
                        end
                        vlbs_pkg::OP_CHECK: begin
                            wbf_reg   <= !fits;
                            state_reg <= S_OUT;
                        end
                        default: begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_PUSH: begin
                    if (cnt_reg == HB_4 + len_reg - 4'd1) begin
                        top_reg   <= base_reg[TW-1:0];
                        state_reg <= S_OUT;
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_HDR: begin
                    rd_hdr_reg  <= 1'b1;
                    rd_slot_reg <= cnt_reg;
                    rd_oob_reg  <= hdr_oob;
                    if (cnt_reg == HB_4 - 4'd1) begin
                        cnt_reg   <= '0;
                        state_reg <= S_HWAIT;
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_HWAIT: begin
                    state_reg <= S_SAT;
                end
                S_SAT: begin
                    n_reg    <= n_c;
                    base_reg <= SW'(top_reg) + HB_S;
                    cnt_reg  <= '0;
                    if (op_reg == vlbs_pkg::OP_POP) begin
                        top_reg <= pop_top;
                    end
                    state_reg <= (n_c == 4'd0) ? S_OUT : S_DATA;
                end
                S_DATA: begin
                    rd_hdr_reg  <= 1'b0;
                    rd_slot_reg <= cnt_reg;
                    rd_oob_reg  <= 1'b0;
                    if (cnt_reg == n_reg - 4'd1) begin
                        state_reg <= S_DWAIT;
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_DWAIT: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result assembly
    always_comb begin
        res_item               = '0;
        res_item.status        = status_reg;
        res_item.out_length    = n_reg;
        res_item.is_empty      = top_reg >= CAP_T;
        res_item.would_be_full = wbf_reg;
        for (int i = 0; i < 8; i++) begin
            res_item.data_out[8*i +: 8] = dat_b[i];
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = state_reg == S_OUT;

endmodule

/* hdl/vlbs_checker.sv */
module vlbs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input vlbs_pkg::vlbs_out_t m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a refused pop or peek leaves the stack empty and copies nothing
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == vlbs_pkg::ST_EMPTY |->
            m_data.is_empty && m_data.out_length == 4'd0 && m_data.data_out == 64'd0)
        else $error("empty refusal with data or non-empty flag");

    // a refused push or a check that reports full copies nothing
    a_nocopy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == vlbs_pkg::ST_FULL || m_data.would_be_full) |->
            m_data.out_length == 4'd0 && m_data.data_out == 64'd0)
        else $error("data copied on full push or check");

    // a zero copy count means zero data
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_length == 4'd0 |-> m_data.data_out == 64'd0)
        else $error("data present with zero length");

endmodule

bind variable_length_byte_stack_core vlbs_checker u_vlbs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* bench/variable_length_byte_stack_core_test.sv */
`timescale 1ns / 100ps

module variable_length_byte_stack_core_test;

    localparam int CAP         = vlbs_pkg::CAPACITY_DEF;
    localparam int HDR         = vlbs_pkg::HEADER_BYTES_DEF;
    localparam int MAXB        = vlbs_pkg::MAX_ELEM_BYTES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // byte stack predictor and store of expected results
    class stack_scoreboard;
        logic [7:0]          stack_mem [0:CAP-1];
        int                  top_index;
        vlbs_pkg::vlbs_out_t expected_results[$];
        int                  errors;

        function new();
            top_index = CAP;
            errors    = 0;
        endfunction

        function bit is_empty();
            return top_index >= CAP;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // one stack operation, updating the predicted state
        function vlbs_pkg::vlbs_out_t stack_step(vlbs_pkg::vlbs_in_t it);
            vlbs_pkg::vlbs_out_t res;
            int len;
            int stored;
            int room;
            int n;
            res = '0;
            len = (it.length > MAXB) ? MAXB : int'(it.length);
            case (it.op)
                vlbs_pkg::OP_PUSH: begin
                    if (top_index < HDR + len) begin
                        res.status = vlbs_pkg::ST_FULL;
                    end else begin
                        top_index -= len;
                        for (int i = 0; i < len; i++)
                            stack_mem[top_index + i] = it.data_in[8*i +: 8];
                        top_index -= HDR;
                        for (int i = 0; i < HDR; i++)
                            stack_mem[top_index + i] = (i < 4) ? 8'(len >> (8*i)) : 8'h00;
                    end
                end
                vlbs_pkg::OP_POP, vlbs_pkg::OP_PEEK: begin
                    if (top_index >= CAP) begin
                        res.status = vlbs_pkg::ST_EMPTY;
                    end else begin
                        // header read back, saturated to element size and memory top
                        stored = 0;
                        for (int i = 0; i < HDR && i < 4; i++)
                            stored |= int'(stack_mem[top_index + i]) << (8*i);
                        if (stored > MAXB) stored = MAXB;
                        room = CAP - top_index;
                        room = (room > HDR) ? room - HDR : 0;
                        if (stored > room) stored = room;
                        n = (len < stored) ? len : stored;
                        for (int i = 0; i < n; i++)
                            res.data_out[8*i +: 8] = stack_mem[top_index + HDR + i];
                        res.out_length = 4'(n);
                        if (it.op == vlbs_pkg::OP_POP) begin
                            top_index += HDR + stored;
                            if (top_index > CAP) top_index = CAP;
                        end
                    end
                end
                vlbs_pkg::OP_CLEAR: top_index = CAP;
                vlbs_pkg::OP_CHECK: res.would_be_full = (top_index < HDR + len);
                default: ;
            endcase
            res.is_empty = (top_index >= CAP);
            return res;
        endfunction

        function void note_op(vlbs_pkg::vlbs_in_t it);
            expected_results.push_back(stack_step(it));
        endfunction

        function void check_result(vlbs_pkg::vlbs_out_t got);
            vlbs_pkg::vlbs_out_t want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d data %h len %0d empty %0b wbf %0b",
                             got.status, got.data_out, got.out_length, got.is_empty,
                             got.would_be_full);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.data_out !== want.data_out ||
                got.out_length !== want.out_length || got.is_empty !== want.is_empty ||
                got.would_be_full !== want.would_be_full) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected status %0d data %h len %0d empty %0b wbf %0b",
                             want.status, want.data_out, want.out_length, want.is_empty,
                             want.would_be_full);
                    $display("          actual   status %0d data %h len %0d empty %0b wbf %0b",
                             got.status, got.data_out, got.out_length, got.is_empty,
                             got.would_be_full);
                end
            end
        endfunction
    endclass

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    vlbs_pkg::vlbs_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    vlbs_pkg::vlbs_out_t m_data;

    stack_scoreboard sb = new();
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;
    bit calm       = 1'b0;
    int sent_count = 0;
    int cycles     = 0;

    variable_length_byte_stack_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // receiver: random stalls, one long hold-off on request, none at the end
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    function automatic vlbs_pkg::vlbs_in_t make_item(logic [2:0] op, int len,
                                                     logic [63:0] data);
        vlbs_pkg::vlbs_in_t it;
        it.op      = op;
        it.length  = 4'(len);
        it.data_in = data;
        return it;
    endfunction

    function automatic logic [63:0] rand_data();
        return {$urandom, $urandom};
    endfunction

    // mostly legal sizes, sometimes above the element limit
    function automatic int rand_len();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    endfunction

    // offer one item and hold it until accepted, then maybe idle
    task automatic send_item(input vlbs_pkg::vlbs_in_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_op(it);
        sent_count++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // random mix of every op
    task automatic run_mixed(input int count);
        int r;
        logic [2:0] op;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 38)      op = vlbs_pkg::OP_PUSH;
            else if (r < 60) op = vlbs_pkg::OP_POP;
            else if (r < 75) op = vlbs_pkg::OP_PEEK;
            else if (r < 87) op = vlbs_pkg::OP_CHECK;
            else if (r < 92) op = vlbs_pkg::OP_CLEAR;
            else             op = 3'($urandom_range(5, 7));
            send_item(make_item(op, rand_len(), rand_data()));
        end
    endtask

    // push until the stack is nearly full, then run into the full refusal
    task automatic run_fill();
        while (sb.top_index >= HDR + MAXB) begin
            if ($urandom_range(0, 5) == 0)
                send_item(make_item(vlbs_pkg::OP_CHECK, rand_len(), rand_data()));
            else
                send_item(make_item(vlbs_pkg::OP_PUSH, $urandom_range(4, 15), rand_data()));
        end
        send_item(make_item(vlbs_pkg::OP_CHECK, MAXB, rand_data()));
        send_item(make_item(vlbs_pkg::OP_PUSH, MAXB, rand_data()));
        send_item(make_item(vlbs_pkg::OP_PUSH, 15, rand_data()));
        send_item(make_item(vlbs_pkg::OP_PEEK, rand_len(), rand_data()));
        send_item(make_item(vlbs_pkg::OP_PUSH, $urandom_range(0, 3), rand_data()));
        send_item(make_item(vlbs_pkg::OP_CHECK, 0, rand_data()));
        send_item(make_item(vlbs_pkg::OP_PUSH, rand_len(), rand_data()));
    endtask

    // pop until empty, then past it
    task automatic run_drain();
        while (!sb.is_empty()) begin
            if ($urandom_range(0, 4) == 0)
                send_item(make_item(vlbs_pkg::OP_PEEK, rand_len(), rand_data()));
            else
                send_item(make_item(vlbs_pkg::OP_POP, rand_len(), rand_data()));
        end
        send_item(make_item(vlbs_pkg::OP_POP, rand_len(), rand_data()));
        send_item(make_item(vlbs_pkg::OP_PEEK, rand_len(), rand_data()));
    endtask

    // stimulus
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty refusals, unused ops, size extremes, saturation, clear
        send_item(make_item(vlbs_pkg::OP_POP, MAXB, rand_data()));
        send_item(make_item(vlbs_pkg::OP_PEEK, 15, rand_data()));
        send_item(make_item(vlbs_pkg::OP_CHECK, 0, rand_data()));
        send_item(make_item(vlbs_pkg::OP_CHECK, 15, rand_data()));
        send_item(make_item(3'd5, 15, '1));
        send_item(make_item(3'd6, 0, '0));
        send_item(make_item(3'd7, 8, rand_data()));
        send_item(make_item(vlbs_pkg::OP_PUSH, 0, '1));
        send_item(make_item(vlbs_pkg::OP_PEEK, MAXB, rand_data()));
        send_item(make_item(vlbs_pkg::OP_POP, 0, rand_data()));
        send_item(make_item(vlbs_pkg::OP_PUSH, MAXB, '1));
        send_item(make_item(vlbs_pkg::OP_PUSH, 15, 64'h0123_4567_89ab_cdef));
        send_item(make_item(vlbs_pkg::OP_PEEK, 3, rand_data()));
        send_item(make_item(vlbs_pkg::OP_POP, 15, rand_data()));
        send_item(make_item(vlbs_pkg::OP_PUSH, 1, '0));
        send_item(make_item(vlbs_pkg::OP_PEEK, 15, rand_data()));
        send_item(make_item(vlbs_pkg::OP_POP, 0, rand_data()));
        send_item(make_item(vlbs_pkg::OP_POP, MAXB, rand_data()));
        send_item(make_item(vlbs_pkg::OP_PUSH, 5, rand_data()));
        send_item(make_item(vlbs_pkg::OP_CLEAR, 0, rand_data()));
        send_item(make_item(vlbs_pkg::OP_POP, MAXB, rand_data()));
        send_item(make_item(vlbs_pkg::OP_CHECK, MAXB, rand_data()));
        wait_drained();

        // receiver holds off while items keep coming
        sent_count = 0;
        hold_req = 1'b1;
        run_mixed(40);
        run_fill();
        run_drain();
        wait_drained();

        while (sent_count < 400) begin
            case ($urandom_range(0, 3))
                0, 1: run_mixed($urandom_range(30, 70));
                2:    run_fill();
                default: run_drain();
            endcase
            if ($urandom_range(0, 2) == 0) wait_drained();
        end

        // last stretch without idling on either side
        calm = 1'b1;
        run_mixed(60);
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
